### src/bwt_pkg.sv
package bwt_pkg;

    // field widths
    localparam int TIME_W  = 40;
    localparam int HIT_W   = 20;
    localparam int SPAN_W  = 24;
    localparam int LIMIT_W = 6;
    localparam int CLASS_W = 3;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 104;

    typedef logic [TIME_W-1:0]  tstamp_t;
    typedef logic [HIT_W-1:0]   hit_t;
    typedef logic [SPAN_W-1:0]  span_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [CLASS_W-1:0] class_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HIT_CUT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HIT_CUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VETO_SPAN_US    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUON_WINDOW_US  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW_US = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MUON_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT     = 3'd6;

    // register reset values
    localparam hit_t   RST_LOW_HIT_CUT     = 20'd11500;
    localparam hit_t   RST_HIGH_HIT_CUT    = 20'd29000;
    localparam span_t  RST_VETO_SPAN_US    = 24'd1500;
    localparam span_t  RST_MUON_WINDOW_US  = 24'd100000;
    localparam span_t  RST_BURST_WINDOW_US = 24'd80000;
    localparam limit_t RST_MUON_LIMIT      = 6'd8;
    localparam limit_t RST_BURST_LIMIT     = 6'd4;

    // event classes
    localparam class_t CLS_NONE         = 3'd0;
    localparam class_t CLS_BURST_KEPT   = 3'd1;
    localparam class_t CLS_BURST_VETOED = 3'd2;
    localparam class_t CLS_MUON_KEPT    = 3'd3;
    localparam class_t CLS_MUON_VETOED  = 3'd4;
    localparam class_t CLS_BELOW_CUTS   = 3'd5;

    // item kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // control from the sequencer to one time store
    typedef struct packed {
        logic push;
        logic pop;
        logic scan_start;
        logic rd_en;
        logic scan_adv;
    } ring_ctrl_t;

endpackage

### src/bwt_ring.sv
module bwt_ring #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bwt_pkg::ring_ctrl_t           ctrl,
    input  bwt_pkg::tstamp_t              push_time,
    output bwt_pkg::tstamp_t              rd_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import bwt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    tstamp_t         mem [DEPTH];
    tstamp_t         rd_data_reg;
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   tail_reg;
    logic [AW-1:0]   ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            full;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign rd_data = rd_data_reg;
    assign count   = count_reg;

    // storage with registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_time;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    // head, tail, fill and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                tail_reg <= wrap_inc(tail_reg);
                // full store drops its oldest entry
                if (full)
                begin
                    head_reg <= wrap_inc(head_reg);
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (ctrl.pop)
            begin
                head_reg  <= wrap_inc(head_reg);
                count_reg <= count_reg - 1'b1;
            end
            if (ctrl.scan_start)
            begin
                ptr_reg <= head_reg;
            end
            else if (ctrl.scan_adv)
            begin
                ptr_reg <= wrap_inc(ptr_reg);
            end
        end
    end

endmodule

### src/burst_window_trigger_with_veto_core.sv
// channel   dir  signals                         contents
// s_t*      in   s_tvalid s_tready s_tdata s_tuser  time_us, hit_count; kind
// m_t*      out  m_tvalid m_tready m_tdata       event class, counts, status, times
// cfg_*     in   cfg_we cfg_index cfg_data       register writes, no read-back
//
// an event goes through accept, classify and store, then hand to the output register
// a tick scans the entries held in the two stores, muon store first; each entry is
// read (ST_RD) and then compared (ST_EV) through one shared window compare
// reset empties both stores at once through their fill counts, no clearing pass
// input is not ready while an item is at work; a waiting result stalls only the
// next result, and the following item is taken while it waits
module burst_window_trigger_with_veto_core #(
    parameter int MUON_DEPTH  = 64,
    parameter int BURST_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bwt_pkg::IN_DATA_W-1:0]       s_tdata,   // time_us, hit_count
    input  logic                                s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // event_class, muon_count, burst_count, trigger_status, muon_trigger_time,
    // burst_trigger_time, zero fill
    output logic [bwt_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [bwt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bwt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bwt_pkg::*;

    localparam int MCW  = $clog2(MUON_DEPTH + 1);
    localparam int BCW  = $clog2(BURST_DEPTH + 1);
    localparam int LW   = (MCW > BCW) ? MCW : BCW;
    localparam int CMPW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int PADW = OUT_DATA_W - (CLASS_W + 2*CNT_W + 2 + 2*TIME_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVT,
        ST_LOW,
        ST_RD,
        ST_EV,
        ST_TRIG,
        ST_OUT
    } state_t;

    state_t          state_reg;

    // configuration
    hit_t            low_cut_reg;
    hit_t            high_cut_reg;
    span_t           veto_reg;
    span_t           muon_win_reg;
    span_t           burst_win_reg;
    limit_t          muon_limit_reg;
    limit_t          burst_limit_reg;

    // item and block state
    tstamp_t         time_reg;
    hit_t            hit_reg;
    class_t          cls_reg;
    tstamp_t         last_muon_reg;
    logic            muon_seen_reg;
    logic [1:0]      flags_reg;
    tstamp_t         muon_fire_reg;
    tstamp_t         burst_fire_reg;

    // scan state
    logic            sel_reg;
    tstamp_t         lo_reg;
    logic [LW-1:0]   left_reg;
    logic [LW-1:0]   n_reg;
    logic [LW-1:0]   nm_reg;
    logic            expiring_reg;

    logic            m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    ring_ctrl_t      muon_ctrl;
    ring_ctrl_t      burst_ctrl;
    ring_ctrl_t      scan_ctrl;
    tstamp_t         muon_rd;
    tstamp_t         burst_rd;
    logic [MCW-1:0]  muon_cnt;
    logic [BCW-1:0]  burst_cnt;

    logic [TIME_W:0] veto_end;
    logic            muon_keep;
    logic            burst_veto;
    class_t          evt_cls;
    span_t           win;
    tstamp_t         lo_calc;
    tstamp_t         entry;
    logic            below_lo;
    logic            below_t;
    logic [LW-1:0]   n_next;
    logic [LW-1:0]   sel_cnt;
    logic            out_free;

    // veto interval and event classification
    assign veto_end   = {1'b0, last_muon_reg} + {{(TIME_W + 1 - SPAN_W){1'b0}}, veto_reg};
    assign muon_keep  = !muon_seen_reg || ({1'b0, time_reg} > veto_end);
    assign burst_veto = muon_seen_reg && (time_reg >= last_muon_reg)
                        && ({1'b0, time_reg} < veto_end);

    always_comb
    begin
        if (hit_reg == '0)
        begin
            evt_cls = CLS_NONE;
        end
        else if (hit_reg > high_cut_reg)
        begin
            evt_cls = muon_keep ? CLS_MUON_KEPT : CLS_MUON_VETOED;
        end
        else if (hit_reg > low_cut_reg)
        begin
            evt_cls = burst_veto ? CLS_BURST_VETOED : CLS_BURST_KEPT;
        end
        else
        begin
            evt_cls = CLS_BELOW_CUTS;
        end
    end

    // window lower bound, saturated at zero
    assign win     = sel_reg ? burst_win_reg : muon_win_reg;
    assign lo_calc = (time_reg >= {{(TIME_W - SPAN_W){1'b0}}, win})
                     ? time_reg - {{(TIME_W - SPAN_W){1'b0}}, win} : '0;

    // shared window compare on the entry just read
    assign entry    = sel_reg ? burst_rd : muon_rd;
    assign below_lo = entry < lo_reg;
    assign below_t  = entry < time_reg;
    assign n_next   = (!below_lo && below_t) ? n_reg + 1'b1 : n_reg;
    assign sel_cnt  = sel_reg ? LW'(burst_cnt) : LW'(muon_cnt);
    assign out_free = !m_tvalid_reg || m_tready;

    // store control
    always_comb
    begin
        scan_ctrl            = '0;
        scan_ctrl.scan_start = (state_reg == ST_LOW);
        scan_ctrl.rd_en      = (state_reg == ST_RD);
        scan_ctrl.scan_adv   = (state_reg == ST_EV);
        scan_ctrl.pop        = (state_reg == ST_EV) && expiring_reg && below_lo;

        muon_ctrl  = sel_reg ? '0 : scan_ctrl;
        burst_ctrl = sel_reg ? scan_ctrl : '0;
        muon_ctrl.push  = (state_reg == ST_EVT) && (evt_cls == CLS_MUON_KEPT);
        burst_ctrl.push = (state_reg == ST_EVT) && (evt_cls == CLS_BURST_KEPT);
    end

    bwt_ring #(
        .DEPTH (MUON_DEPTH)
    ) u_muon_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (muon_ctrl),
        .push_time (time_reg),
        .rd_data   (muon_rd),
        .count     (muon_cnt)
    );

    bwt_ring #(
        .DEPTH (BURST_DEPTH)
    ) u_burst_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (burst_ctrl),
        .push_time (time_reg),
        .rd_data   (burst_rd),
        .count     (burst_cnt)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cut_reg     <= RST_LOW_HIT_CUT;
            high_cut_reg    <= RST_HIGH_HIT_CUT;
            veto_reg        <= RST_VETO_SPAN_US;
            muon_win_reg    <= RST_MUON_WINDOW_US;
            burst_win_reg   <= RST_BURST_WINDOW_US;
            muon_limit_reg  <= RST_MUON_LIMIT;
            burst_limit_reg <= RST_BURST_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_HIT_CUT:     low_cut_reg     <= cfg_data[HIT_W-1:0];
                REG_HIGH_HIT_CUT:    high_cut_reg    <= cfg_data[HIT_W-1:0];
                REG_VETO_SPAN_US:    veto_reg        <= cfg_data[SPAN_W-1:0];
                REG_MUON_WINDOW_US:  muon_win_reg    <= cfg_data[SPAN_W-1:0];
                REG_BURST_WINDOW_US: burst_win_reg   <= cfg_data[SPAN_W-1:0];
                REG_MUON_LIMIT:      muon_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_BURST_LIMIT:     burst_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_muon_reg  <= '0;
            muon_seen_reg  <= 1'b0;
            flags_reg      <= '0;
            muon_fire_reg  <= '0;
            burst_fire_reg <= '0;
            sel_reg        <= 1'b0;
            expiring_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // result taken; a new one loaded in ST_OUT sets valid there instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        time_reg  <= s_tdata[TIME_W-1:0];
                        hit_reg   <= s_tdata[TIME_W +: HIT_W];
                        sel_reg   <= 1'b0;
                        state_reg <= (s_tuser == KIND_TICK) ? ST_LOW : ST_EVT;
                    end
                end
                ST_EVT:
                begin
                    cls_reg <= evt_cls;
                    if (evt_cls == CLS_MUON_KEPT)
                    begin
                        last_muon_reg <= time_reg;
                        muon_seen_reg <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_LOW:
                begin
                    lo_reg       <= lo_calc;
                    left_reg     <= sel_cnt;
                    n_reg        <= '0;
                    expiring_reg <= 1'b1;
                    if (sel_cnt != '0)
                    begin
                        state_reg <= ST_RD;
                    end
                    else if (!sel_reg)
                    begin
                        nm_reg  <= '0;
                        sel_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_TRIG;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EV;
                end
                ST_EV:
                begin
                    // expiry stops at the first entry inside the window
                    if (!below_lo)
                    begin
                        expiring_reg <= 1'b0;
                    end
                    n_reg    <= n_next;
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == LW'(1))
                    begin
                        if (!sel_reg)
                        begin
                            nm_reg    <= n_next;
                            sel_reg   <= 1'b1;
                            state_reg <= ST_LOW;
                        end
                        else
                        begin
                            state_reg <= ST_TRIG;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_TRIG:
                begin
                    cls_reg <= CLS_NONE;
                    if (!flags_reg[1] && (CMPW'(nm_reg) > CMPW'(muon_limit_reg)))
                    begin
                        flags_reg[1]  <= 1'b1;
                        muon_fire_reg <= time_reg;
                    end
                    if (!flags_reg[0] && (CMPW'(n_reg) > CMPW'(burst_limit_reg)))
                    begin
                        flags_reg[0]   <= 1'b1;
                        burst_fire_reg <= time_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{PADW{1'b0}}, burst_fire_reg, muon_fire_reg,
                                         flags_reg, CNT_W'(burst_cnt), CNT_W'(muon_cnt),
                                         cls_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### bench/tb.sv
module tb;
    import bwt_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 300;
    localparam int TICK_PCT     = 25;

    localparam int BURST_STORE = 0;
    localparam int MUON_STORE  = 1;

    // result field offsets in m_tdata
    localparam int CLS_LSB   = 0;
    localparam int MCNT_LSB  = CLS_LSB + CLASS_W;
    localparam int BCNT_LSB  = MCNT_LSB + CNT_W;
    localparam int STAT_LSB  = BCNT_LSB + CNT_W;
    localparam int MFIRE_LSB = STAT_LSB + 2;
    localparam int BFIRE_LSB = MFIRE_LSB + TIME_W;

    localparam tstamp_t TIME_MAX  = '1;
    localparam hit_t    HIT_MAX   = '1;
    localparam span_t   SPAN_MAX  = '1;
    localparam limit_t  LIMIT_MAX = '1;

    typedef struct {
        logic    kind;
        tstamp_t time_us;
        hit_t    hits;
    } det_item_t;

    typedef struct {
        class_t           cls;
        logic [CNT_W-1:0] muon_cnt;
        logic [CNT_W-1:0] burst_cnt;
        logic [1:0]       status;
        tstamp_t          muon_fire;
        tstamp_t          burst_fire;
    } report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    hit_t   low_cut   = RST_LOW_HIT_CUT;
    hit_t   high_cut  = RST_HIGH_HIT_CUT;
    span_t  veto_span = RST_VETO_SPAN_US;
    span_t  muon_win  = RST_MUON_WINDOW_US;
    span_t  burst_win = RST_BURST_WINDOW_US;
    limit_t muon_lim  = RST_MUON_LIMIT;
    limit_t burst_lim = RST_BURST_LIMIT;

    // predictor copy of the trigger state
    tstamp_t    kept_times[2][$];
    tstamp_t    last_muon = '0;
    logic       muon_seen = 1'b0;
    logic [1:0] fire_flags = 2'b00;
    tstamp_t    muon_fire_at = '0;
    tstamp_t    burst_fire_at = '0;

    det_item_t  event_feed[$];
    report_t    due_reports[$];
    det_item_t  in_flight;
    report_t    head_report;
    tstamp_t    clock_us = '0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    burst_window_trigger_with_veto_core #(
        .MUON_DEPTH  (STORE_DEPTH),
        .BURST_DEPTH (STORE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // push into a time store, oldest entry dropped when full
    function automatic void keep_time(int which, tstamp_t t);
        if (kept_times[which].size() >= STORE_DEPTH)
            void'(kept_times[which].pop_front());
        kept_times[which].insert(kept_times[which].size(), t);
    endfunction

    // expire old head entries, then count entries in [t-w, t)
    function automatic int unsigned window_count(int which, tstamp_t t, span_t w);
        tstamp_t     lo;
        int unsigned n;
        lo = (t >= w) ? t - w : '0;
        n = 0;
        while (kept_times[which].size() > 0 && kept_times[which][0] < lo)
            void'(kept_times[which].pop_front());
        for (int i = 0; i < kept_times[which].size(); i++)
            if (kept_times[which][i] >= lo && kept_times[which][i] < t)
                n++;
        return n;
    endfunction

    // classify an event or run a tick, and form the report it causes
    function automatic report_t predict_report(det_item_t it);
        report_t          r;
        logic [TIME_W:0]  veto_end;
        int unsigned      nm;
        int unsigned      nb;
        r.cls = CLS_NONE;
        veto_end = {1'b0, last_muon} + veto_span;
        if (it.kind == KIND_EVENT)
        begin
            if (it.hits == '0)
                r.cls = CLS_NONE;
            else if (it.hits > high_cut)
            begin
                if (!muon_seen || {1'b0, it.time_us} > veto_end)
                begin
                    keep_time(MUON_STORE, it.time_us);
                    last_muon = it.time_us;
                    muon_seen = 1'b1;
                    r.cls = CLS_MUON_KEPT;
                end
                else
                    r.cls = CLS_MUON_VETOED;
            end
            else if (it.hits > low_cut)
            begin
                if (muon_seen && it.time_us >= last_muon && {1'b0, it.time_us} < veto_end)
                    r.cls = CLS_BURST_VETOED;
                else
                begin
                    keep_time(BURST_STORE, it.time_us);
                    r.cls = CLS_BURST_KEPT;
                end
            end
            else
                r.cls = CLS_BELOW_CUTS;
        end
        else
        begin
            nm = window_count(MUON_STORE, it.time_us, muon_win);
            nb = window_count(BURST_STORE, it.time_us, burst_win);
            if (!fire_flags[1] && nm > muon_lim)
            begin
                fire_flags[1] = 1'b1;
                muon_fire_at = it.time_us;
            end
            if (!fire_flags[0] && nb > burst_lim)
            begin
                fire_flags[0] = 1'b1;
                burst_fire_at = it.time_us;
            end
        end
        r.muon_cnt = CNT_W'(kept_times[MUON_STORE].size());
        r.burst_cnt = CNT_W'(kept_times[BURST_STORE].size());
        r.status = fire_flags;
        r.muon_fire = muon_fire_at;
        r.burst_fire = burst_fire_at;
        return r;
    endfunction

    function automatic void check_field(string name, tstamp_t want, tstamp_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // hit count spread over the current cut bands
    function automatic hit_t pick_hits();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return HIT_MAX;
        if (r < 15)
            return hit_t'($urandom);
        if (r < 35)
            return hit_t'($urandom_range(low_cut));
        if (r < 70)
            return (high_cut > low_cut) ? hit_t'($urandom_range(high_cut, low_cut + 1))
                                        : hit_t'($urandom);
        return (high_cut < HIT_MAX) ? hit_t'($urandom_range(HIT_MAX, high_cut + 1)) : HIT_MAX;
    endfunction

    // next item time: mostly forward on veto and window scales, seldom backward
    function automatic tstamp_t advance_time(tstamp_t now);
        logic [TIME_W:0] next;
        tstamp_t         step;
        int unsigned     r;
        int unsigned     win;
        win = (muon_win > burst_win) ? muon_win : burst_win;
        r = $urandom_range(99);
        if (r < 3)
            return (now > veto_span) ? now - $urandom_range(veto_span) : '0;
        if (r < 18)
            step = '0;
        else if (r < 50)
            step = $urandom_range(veto_span + 2);
        else if (r < 90)
            step = $urandom_range(win / 16 + 1);
        else
            step = $urandom_range(win);
        next = {1'b0, now} + step;
        return next[TIME_W] ? TIME_MAX : next[TIME_W-1:0];
    endfunction

    function automatic void queue_item(logic kind, tstamp_t t, hit_t hits);
        det_item_t it;
        it.kind = kind;
        it.time_us = t;
        it.hits = hits;
        event_feed.insert(event_feed.size(), it);
    endfunction

    function automatic void queue_random(int n);
        clock_us = {8'($urandom_range(254)), 32'($urandom)};
        for (int i = 0; i < n; i++)
        begin
            clock_us = advance_time(clock_us);
            queue_item(($urandom_range(99) < TICK_PCT) ? KIND_TICK : KIND_EVENT,
                       clock_us, pick_hits());
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_LOW_HIT_CUT:     low_cut = hit_t'(value);
            REG_HIGH_HIT_CUT:    high_cut = hit_t'(value);
            REG_VETO_SPAN_US:    veto_span = span_t'(value);
            REG_MUON_WINDOW_US:  muon_win = span_t'(value);
            REG_BURST_WINDOW_US: burst_win = span_t'(value);
            REG_MUON_LIMIT:      muon_lim = limit_t'(value);
            REG_BURST_LIMIT:     burst_lim = limit_t'(value);
            default:             ;
        endcase
    endtask

    task automatic apply_setting(hit_t lo, hit_t hi, span_t veto, span_t mwin, span_t bwin,
                                 limit_t mlim, limit_t blim);
        write_reg(REG_LOW_HIT_CUT, CFG_DATA_W'(lo));
        write_reg(REG_HIGH_HIT_CUT, CFG_DATA_W'(hi));
        write_reg(REG_VETO_SPAN_US, veto);
        write_reg(REG_MUON_WINDOW_US, mwin);
        write_reg(REG_BURST_WINDOW_US, bwin);
        write_reg(REG_MUON_LIMIT, CFG_DATA_W'(mlim));
        write_reg(REG_BURST_LIMIT, CFG_DATA_W'(blim));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block idle: nothing left to send and every report back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_feed.size() != 0 || s_tvalid || due_reports.size() != 0);
    endtask

    // item driver, predicts each item as it is taken
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (s_tvalid)
                due_reports.insert(due_reports.size(), predict_report(in_flight));
            if (event_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_flight = event_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(IN_DATA_W - TIME_W - HIT_W){1'b0}}, in_flight.hits,
                            in_flight.time_us};
                s_tuser <= in_flight.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // report monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: report with none expected, expected nothing, got %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    head_report = due_reports.pop_front();
                    check_field("event_class", TIME_W'(head_report.cls),
                                TIME_W'(m_tdata[CLS_LSB +: CLASS_W]));
                    check_field("muon_count", TIME_W'(head_report.muon_cnt),
                                TIME_W'(m_tdata[MCNT_LSB +: CNT_W]));
                    check_field("burst_count", TIME_W'(head_report.burst_cnt),
                                TIME_W'(m_tdata[BCNT_LSB +: CNT_W]));
                    check_field("trigger_status", TIME_W'(head_report.status),
                                TIME_W'(m_tdata[STAT_LSB +: 2]));
                    check_field("muon_trigger_time", head_report.muon_fire,
                                m_tdata[MFIRE_LSB +: TIME_W]);
                    check_field("burst_trigger_time", head_report.burst_fire,
                                m_tdata[BFIRE_LSB +: TIME_W]);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at reset settings
        queue_item(KIND_TICK, '0, '0);                 // empty window at time zero
        queue_item(KIND_EVENT, 40'd10, '0);            // zero hits
        queue_item(KIND_EVENT, 40'd20, 20'd11500);     // at low cut, below
        queue_item(KIND_EVENT, 40'd30, 20'd11501);     // burst, no muon yet
        queue_item(KIND_EVENT, 40'd40, 20'd29000);     // at high cut, burst-like
        queue_item(KIND_EVENT, 40'd1000, 20'd29001);   // first muon always kept
        queue_item(KIND_EVENT, 40'd2500, HIT_MAX);     // muon at last + span, vetoed
        queue_item(KIND_EVENT, 40'd1000, 20'd20000);   // burst at last muon, vetoed
        queue_item(KIND_EVENT, 40'd2499, 20'd20000);   // burst just inside veto
        queue_item(KIND_EVENT, 40'd2500, 20'd20000);   // burst at veto end, kept
        queue_item(KIND_EVENT, 40'd2501, 20'd29001);   // muon past veto, kept
        queue_item(KIND_TICK, 40'd2501, HIT_MAX);      // entry at tick time not counted
        queue_item(KIND_TICK, 40'd101001, '0);         // expiry of old entries
        queue_item(KIND_EVENT, 40'd101001, 20'd1);     // below cuts
        queue_item(KIND_EVENT, TIME_MAX, 20'd20000);   // burst at top of time range
        queue_item(KIND_EVENT, TIME_MAX, 20'd500000);  // muon at top of time range
        queue_item(KIND_EVENT, TIME_MAX, 20'd500000);  // muon vetoed, no wrap
        queue_item(KIND_EVENT, TIME_MAX, 20'd20000);   // burst vetoed, no wrap
        queue_item(KIND_TICK, TIME_MAX, '0);           // tick at top of time range
        queue_item(KIND_EVENT, 40'd5000, 20'd30000);   // muon out of order
        queue_item(KIND_TICK, 40'd5001, '0);
        wait_drained();

        // limits held high, otherwise reset settings, no idling
        apply_setting(RST_LOW_HIT_CUT, RST_HIGH_HIT_CUT, RST_VETO_SPAN_US, RST_MUON_WINDOW_US,
                      RST_BURST_WINDOW_US, LIMIT_MAX, LIMIT_MAX);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // no muons, everything nonzero burst-like, no veto, shortest burst window
        send_idle_pct = 81;
        apply_setting('0, HIT_MAX, '0, 24'd50000, 24'd1, LIMIT_MAX, LIMIT_MAX);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // everything nonzero muon-like, longest veto and muon window
        send_idle_pct = 0;
        stall_pct = 81;
        apply_setting(HIT_MAX, '0, SPAN_MAX, SPAN_MAX, 24'd1, LIMIT_MAX, LIMIT_MAX);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // random cuts and windows, both sides idling
        send_idle_pct = 31;
        stall_pct = 31;
        apply_setting(hit_t'($urandom_range(30000, 1)), hit_t'($urandom_range(70000, 20000)),
                      span_t'($urandom_range(5000)), span_t'($urandom_range(300000, 1000)),
                      span_t'($urandom_range(300000, 1000)), LIMIT_MAX, LIMIT_MAX);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // low limits and longest windows, both triggers fire and latch
        send_idle_pct = 0;
        stall_pct = 0;
        apply_setting(RST_LOW_HIT_CUT, RST_HIGH_HIT_CUT, 24'd200, SPAN_MAX, SPAN_MAX,
                      limit_t'(3), '0);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // fully random settings after the triggers latched
        send_idle_pct = 31;
        stall_pct = 31;
        apply_setting(hit_t'($urandom_range(40000)), hit_t'($urandom_range(80000)),
                      span_t'($urandom_range(20000)), span_t'($urandom_range(400000, 1)),
                      span_t'($urandom_range(400000, 1)), limit_t'($urandom),
                      limit_t'($urandom));
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
src/bwt_pkg.sv
src/bwt_ring.sv
src/burst_window_trigger_with_veto_core.sv
bench/tb.sv
